>>> rtl/core/bbss_pkg.sv
// ----------------------------------------------------------------------------
// bbss_pkg
// Shared types and constants of the cubic B-spline subpixel sampler.
// ----------------------------------------------------------------------------
package bbss_pkg;

    // item kinds on the input channel
    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd1;
    localparam int CFG_BITS = 9;

    // x / 6 == (x * RECIP6_MUL) >> RECIP6_SHIFT for x < 2^23
    localparam int RECIP6_SHIFT = 24;
    localparam logic [21:0] RECIP6_MUL = 22'd2796203;
    localparam int WGT_BITS = 16;
    localparam int X_BITS   = 20;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WGT  = 4'b0010,
        S_ROW  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic       accept_wr;
        logic       accept_q;
        logic       wgt_issue;
        logic       row_issue;
        logic [1:0] idx;
        logic       out_load;
    } t_cmd;

endpackage

>>> rtl/core/bbss_ram.sv
// ----------------------------------------------------------------------------
// bbss_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/bbss_weight.sv
// ----------------------------------------------------------------------------
// bbss_weight
// Three-stage cubic B-spline kernel weight of a distance magnitude, Q.16 out.
// ----------------------------------------------------------------------------
module bbss_weight #(
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [1:0]               i_tag,
    input  logic [POS_FRAC_BITS+1:0] i_a,
    output logic                     o_vld,
    output logic [1:0]               o_tag,
    output logic [15:0]              o_w
);
    import bbss_pkg::*;

    localparam int F   = POS_FRAC_BITS;
    localparam int AB  = F + 2;
    localparam int SQB = 2 * F + 2;
    localparam int MB  = F + 3;
    localparam int PB  = SQB + MB;
    localparam int NB  = 3 * F + 3;
    localparam int TB  = NB + 17;
    localparam int S3  = (3 * F >= 16) ? 3 * F - 16 : 0;
    localparam int S4  = (3 * F >= 16) ? 0 : 16 - 3 * F;

    localparam logic [AB-1:0] ONE     = AB'(1) << F;
    localparam logic [AB-1:0] TWO_ONE = AB'(2) << F;
    localparam logic [MB-1:0] SIX_ONE = MB'(6) << F;
    localparam logic [NB-1:0] FOUR_ONE3 = NB'(4) << (3 * F);

    logic            lt, zr;
    logic [F:0]      x;
    logic [MB-1:0]   m;
    logic [SQB-1:0]  r_sq;
    logic [MB-1:0]   r_m;
    logic            r_lt, r_zr1, r_zr2;
    logic [PB-1:0]   p;
    logic [NB-1:0]   n;
    logic [NB-1:0]   r_n;
    logic [X_BITS-1:0] xv;
    logic [X_BITS+21:0] q;
    logic [2:0]      r_vld;
    logic [1:0]      r_tag1, r_tag2;

    always_comb begin
        lt = (i_a < ONE);
        zr = (i_a >= TWO_ONE);
        x  = lt ? i_a[F:0] : (F+1)'(TWO_ONE - i_a);
        m  = lt ? MB'(SIX_ONE - MB'(3 * i_a)) : MB'(x);
    end

    always_comb begin
        p = PB'(r_sq) * PB'(r_m);
        n = r_lt ? NB'(FOUR_ONE3 - NB'(p)) : NB'(p);
    end

    // rounding half up, then divide by six
    if (3 * F >= 16) begin : g_hi
        assign xv = X_BITS'((TB'(r_n) + (TB'(3) << S3)) >> S3);
    end else begin : g_lo
        assign xv = X_BITS'((TB'(r_n) << S4) + TB'(3));
    end

    assign q = (X_BITS+22)'(xv) * (X_BITS+22)'(RECIP6_MUL);

    always_ff @(posedge i_clk) begin
        r_sq   <= SQB'(x) * SQB'(x);
        r_m    <= m;
        r_lt   <= lt;
        r_zr1  <= zr;
        r_n    <= n;
        r_zr2  <= r_zr1;
        o_w    <= r_zr2 ? 16'd0 : q[RECIP6_SHIFT+15:RECIP6_SHIFT];
        r_tag1 <= i_tag;
        r_tag2 <= r_tag1;
        o_tag  <= r_tag2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld = r_vld[2];
endmodule

>>> rtl/core/bbss_datapath.sv
// ----------------------------------------------------------------------------
// bbss_datapath
// Pixel store in four column banks, position split, weights and the MAC.
// ----------------------------------------------------------------------------
module bbss_datapath #(
    parameter int MAX_ROWS      = 256,
    parameter int MAX_COLS      = 256,
    parameter int PIXEL_BITS    = 16,
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bbss_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [bbss_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic [7:0]                          i_pixel_row,
    input  logic [7:0]                          i_pixel_col,
    input  logic signed [15:0]                  i_pixel_value,
    input  logic signed [17:0]                  i_query_row,
    input  logic signed [17:0]                  i_query_col,
    input  bbss_pkg::t_cmd                      i_cmd,
    output logic signed [31:0]                  o_interpolated
);
    import bbss_pkg::*;

    localparam int F     = POS_FRAC_BITS;
    localparam int COLW  = (MAX_COLS + 3) / 4;
    localparam int DEPTH = MAX_ROWS * COLW;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int WDW   = (COLW > 1) ? $clog2(COLW) : 1;
    localparam int IPW   = 19;
    localparam int TW    = 20;
    localparam int DW    = F + 4;
    localparam int PRW   = PIXEL_BITS + 18;
    localparam int ACCW  = (PIXEL_BITS + 22 > 33) ? PIXEL_BITS + 22 : 33;
    localparam logic signed [ACCW-1:0] SAT_MAX = ACCW'(64'sh7FFFFFFF);
    localparam logic signed [ACCW-1:0] SAT_MIN = ACCW'(-64'sh80000000);

    logic [CFG_BITS-1:0] r_h, r_w;
    logic signed [TW-1:0] h_eff, w_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= CFG_BITS'(256);
            r_w <= CFG_BITS'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEIGHT: r_h <= i_cfg_data;
                CFG_WIDTH:  r_w <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign h_eff = (32'(r_h) < MAX_ROWS) ? TW'(r_h) : TW'(MAX_ROWS);
    assign w_eff = (32'(r_w) < MAX_COLS) ? TW'(r_w) : TW'(MAX_COLS);

    // ---- position split: integer part toward zero, signed fraction ----
    logic [17:0]           mag_r, mag_c;
    logic signed [IPW-1:0] ip_r, ip_c;
    logic signed [F:0]     fr_r, fr_c;
    logic signed [IPW-1:0] r_ipr, r_ipc;
    logic signed [F:0]     r_frr, r_frc;

    always_comb begin
        mag_r = i_query_row[17] ? 18'(-i_query_row) : i_query_row;
        mag_c = i_query_col[17] ? 18'(-i_query_col) : i_query_col;
        ip_r  = i_query_row[17] ? -IPW'(mag_r >> F) : IPW'(mag_r >> F);
        ip_c  = i_query_col[17] ? -IPW'(mag_c >> F) : IPW'(mag_c >> F);
        fr_r  = i_query_row[17] ? -(F+1)'({1'b0, mag_r[F-1:0]})
                                :  (F+1)'({1'b0, mag_r[F-1:0]});
        fr_c  = i_query_col[17] ? -(F+1)'({1'b0, mag_c[F-1:0]})
                                :  (F+1)'({1'b0, mag_c[F-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_q) begin
            r_ipr <= ip_r;
            r_ipc <= ip_c;
            r_frr <= fr_r;
            r_frc <= fr_c;
        end
    end

    // ---- kernel weights, one row and one column offset per cycle ----
    logic signed [2:0]    k_s;
    logic signed [DW-1:0] d_r, d_c;
    logic [F+1:0]         a_r, a_c;
    logic                 wv;
    logic [1:0]           wtag, wtag_c;
    logic [15:0]          w_r, w_c;
    logic                 wv_c;
    logic [15:0]          r_wr [4];
    logic [15:0]          r_wc [4];

    assign k_s = $signed({1'b0, i_cmd.idx}) - 3'sd1;

    always_comb begin
        d_r = (DW'(k_s) <<< F) - DW'(r_frr);
        d_c = (DW'(k_s) <<< F) - DW'(r_frc);
        a_r = d_r[DW-1] ? (F+2)'(-d_r) : (F+2)'(d_r);
        a_c = d_c[DW-1] ? (F+2)'(-d_c) : (F+2)'(d_c);
    end

    bbss_weight #(.POS_FRAC_BITS(F)) u_wgt_row (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_cmd.wgt_issue),
        .i_tag(i_cmd.idx), .i_a(a_r), .o_vld(wv), .o_tag(wtag), .o_w(w_r)
    );

    bbss_weight #(.POS_FRAC_BITS(F)) u_wgt_col (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_cmd.wgt_issue),
        .i_tag(i_cmd.idx), .i_a(a_c), .o_vld(wv_c), .o_tag(wtag_c), .o_w(w_c)
    );

    always_ff @(posedge i_clk) begin
        if (wv) begin
            r_wr[wtag] <= w_r;
        end
        if (wv_c) begin
            r_wc[wtag_c] <= w_c;
        end
    end

    // ---- pixel store: bank b holds columns with col mod 4 == b ----
    logic signed [31:0]      pv32;
    logic [PIXEL_BITS-1:0]   wdata;
    logic                    wr_ok;
    logic [AW-1:0]           waddr;
    logic signed [TW-1:0]    tr, base;
    logic [AW-1:0]           raddr [4];
    logic [PIXEL_BITS-1:0]   rdata [4];

    assign pv32  = 32'(i_pixel_value);
    assign wdata = PIXEL_BITS'(pv32);
    assign wr_ok = i_cmd.accept_wr && (32'(i_pixel_row) < MAX_ROWS)
                   && (32'(i_pixel_col) < MAX_COLS);
    assign waddr = AW'(32'(i_pixel_row) * COLW + 32'(i_pixel_col >> 2));

    assign tr   = TW'(r_ipr) + TW'(k_s);
    assign base = TW'(r_ipc) - TW'(1);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [1:0]           j_b;
        logic signed [TW-1:0] col_b;

        assign j_b   = 2'(2'(b) - base[1:0]);
        assign col_b = base + TW'(j_b);
        assign raddr[b] = AW'(32'(tr[RW-1:0]) * COLW + 32'(col_b[WDW+1:2]));

        bbss_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_ram (
            .i_clk(i_clk),
            .i_we(wr_ok && (i_pixel_col[1:0] == 2'(b))),
            .i_waddr(waddr), .i_wdata(wdata),
            .i_raddr(raddr[b]), .o_rdata(rdata[b])
        );
    end

    // ---- MAC: issue row, multiply, accumulate ----
    logic                     row_ok;
    logic [16:0]              r_w2 [4];
    logic [3:0]               r_lv;
    logic [1:0]               r_rot;
    logic                     r_v1, r_v2;
    logic signed [PRW-1:0]    r_p [4];
    logic signed [ACCW-1:0]   r_acc;
    logic signed [ACCW-1:0]   psum;

    assign row_ok = (tr >= 0) && (tr < h_eff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_issue) begin
            r_rot <= base[1:0];
        end
        for (int j = 0; j < 4; j++) begin
            logic signed [TW-1:0] tc;
            tc = TW'(r_ipc) + TW'(j) - TW'(1);
            r_w2[j] <= 17'((33'(r_wr[i_cmd.idx]) * 33'(r_wc[j]) + 33'd32768) >> 16);
            r_lv[j] <= row_ok && (tc >= 0) && (tc < w_eff);
            r_p[j]  <= r_lv[j]
                ? PRW'($signed(rdata[2'(r_rot + 2'(j))]) * $signed({1'b0, r_w2[j]}))
                : '0;
        end
    end

    always_comb begin
        psum = '0;
        for (int j = 0; j < 4; j++) begin
            psum = psum + ACCW'(r_p[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.row_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_q) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + psum;
        end
        if (i_cmd.out_load) begin
            o_interpolated <= (r_acc > SAT_MAX) ? 32'sh7FFFFFFF
                            : (r_acc < SAT_MIN) ? -32'sh80000000
                            : 32'(r_acc);
        end
    end
endmodule

>>> rtl/core/bbss_ctrl.sv
// ----------------------------------------------------------------------------
// bbss_ctrl
// Sequencer: accept, weight phase, row phase, result hand-off.
// ----------------------------------------------------------------------------
module bbss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_action,
    input  logic           i_out_stall,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output bbss_pkg::t_cmd o_cmd
);
    import bbss_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt + 3'd1;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.idx   = r_cnt[1:0];
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    if (i_action == ACTION_QUERY) begin
                        o_cmd.accept_q = 1'b1;
                        n_state = S_WGT;
                    end else begin
                        o_cmd.accept_wr = 1'b1;
                    end
                end
            end
            S_WGT: begin
                o_cmd.wgt_issue = (r_cnt < 3'd4);
                // last weight leaves the three-stage unit at count 6
                if (r_cnt == 3'd6) begin
                    n_cnt   = '0;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.row_issue = (r_cnt < 3'd4);
                if (r_cnt == 3'd5) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

>>> rtl/core/bicubic_bspline_subpixel_sample.sv
// ----------------------------------------------------------------------------
// bicubic_bspline_subpixel_sample
// Cubic B-spline 4x4 interpolation over an image held in on-chip RAM.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): a write item (i_action = 0)
// stores i_pixel_value at (i_pixel_row, i_pixel_col); the next item is
// accepted in the following cycle. A query item (i_action = 1) takes Q9.8
// i_query_row / i_query_col and yields one item on the output channel
// (o_out_valid / i_out_stall), o_interpolated in Q.16.
// A query holds the input stalled through the kernel weights (two
// three-stage weight units, one offset per cycle), the row reads (one
// 4-pixel row per cycle from four column-banked RAMs, then multiply and
// accumulate) and the load of the output register, so no new item is
// accepted until the query has loaded its result.
// The result sits in an output register; a stalled receiver holds it and a
// finished query waits in the last step until the register is free.
// Reset clears control state and sets height and width to 256; pixel RAM is
// not cleared, so pixels must be written before they are read.
// ----------------------------------------------------------------------------
module bicubic_bspline_subpixel_sample #(
    parameter int MAX_ROWS      = 256,
    parameter int MAX_COLS      = 256,
    parameter int PIXEL_BITS    = 16,
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bbss_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [bbss_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [7:0]                        i_pixel_row,
    input  logic [7:0]                        i_pixel_col,
    input  logic signed [15:0]                i_pixel_value,
    input  logic signed [17:0]                i_query_row,
    input  logic signed [17:0]                i_query_col,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_interpolated
);
    import bbss_pkg::*;

    t_cmd cmd;

    bbss_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_action(i_action),
        .i_out_stall(i_out_stall), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_cmd(cmd)
    );

    bbss_datapath #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
        .PIXEL_BITS(PIXEL_BITS), .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pixel_row(i_pixel_row), .i_pixel_col(i_pixel_col),
        .i_pixel_value(i_pixel_value),
        .i_query_row(i_query_row), .i_query_col(i_query_col),
        .i_cmd(cmd), .o_interpolated(o_interpolated)
    );
endmodule
